FILE: sv/scdt_pkg.sv
// ----------------------------------------------------------------------------
// Scaled integer to decimal text: shared package
// Types, constants and helper functions used by the conversion unit and the
// top level.
// ----------------------------------------------------------------------------
package scdt_pkg;

   localparam int MinScaleDefault = -18;

   localparam int ValueWidth = 64;
   localparam int ScaleWidth = 7;
   localparam int CharWidth  = 8;

   // A magnitude of at most 2**63 has at most nineteen decimal digits.
   localparam int BcdDigits   = 19;
   localparam int BcdWidth    = BcdDigits * 4;
   localparam int BitsPerStep = 2;
   localparam int StepCount   = ValueWidth / BitsPerStep;
   localparam int StepWidth   = $clog2(StepCount);

   // Wide enough for a digit count or a fraction length of up to nineteen.
   localparam int RemWidth = 5;

   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChPoint = 8'h2E;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
   localparam logic [CharWidth-1:0] ChStar  = 8'h2A;

   typedef logic [BcdWidth-1:0] bcd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      TXT_NUM,
      TXT_ZERO,
      TXT_STAR
   } text_mode_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dbl_status_type;

   // One shift-and-add-three step: correct every digit of five or more, then
   // shift the new binary bit in at the bottom.
   function automatic bcd_type dabble_bit(bcd_type bcd, logic bit_in);
      bcd_type adj;
      adj = bcd;
      for (int d = 0; d < BcdDigits; d++) begin
         if (adj[d*4 +: 4] >= 4'd5) begin
            adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
         end
      end
      return {adj[BcdWidth-2:0], bit_in};
   endfunction

   // Number of significant decimal digits.
   function automatic logic [RemWidth-1:0] digit_count(bcd_type bcd);
      logic [RemWidth-1:0] n;
      n = '0;
      for (int d = 0; d < BcdDigits; d++) begin
         if (bcd[d*4 +: 4] != 4'd0) begin
            n = RemWidth'(d + 1);
         end
      end
      return n;
   endfunction

endpackage

FILE: sv/scdt_dabble.sv
// ----------------------------------------------------------------------------
// Scaled integer to decimal text: binary to BCD unit
// Iterative double dabble, two binary bits per cycle through two chained
// add-three and shift steps.
// ----------------------------------------------------------------------------
module scdt_dabble (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [scdt_pkg::ValueWidth-1:0]     mag,
   output scdt_pkg::bcd_type                   bcd,
   output scdt_pkg::dbl_status_type            status
);
   import scdt_pkg::*;

   logic [ValueWidth-1:0] bin_ff,  bin_in;
   bcd_type               bcd_ff,  bcd_in;
   logic [StepWidth-1:0]  cnt_ff,  cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      bcd_type acc;
      acc     = bcd_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int b = 0; b < BitsPerStep; b++) begin
         acc = dabble_bit(acc, bin_ff[ValueWidth-1-b]);
      end
      if (start) begin
         bin_in  = mag;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in = bin_ff << BitsPerStep;
         bcd_in = acc;
         cnt_in = cnt_ff + StepWidth'(1);
         if (cnt_ff == StepWidth'(StepCount - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd         = bcd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: sv/scaled_integer_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// Scaled integer to decimal text unit
// Turns a signed 64-bit integer and a decimal scale into ASCII text, one
// character per response, with a mark on the final character.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    req_value (s64), req_scale (s7)
//   rsp_      out         rsp_valid/rsp_ready    rsp_text_char (u8), rsp_last
//
// A request is accepted, converted in the double dabble unit (two bits per
// cycle over 64 bits, then its finish flag is registered), its digits are
// counted and then its characters are sent in order, at most 21 of them.
// A zero value or an out-of-range scale skips the conversion and goes
// straight to the characters. The unit takes one request at a time.
// Reset is synchronous and clears the sequencer and the response valid.
// A stalled response holds its character; the sequencer waits for it.
//
module scaled_integer_to_decimal_text_unit #(
   parameter int MIN_SCALE = scdt_pkg::MinScaleDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [scdt_pkg::ValueWidth-1:0] req_value,
   input  logic signed [scdt_pkg::ScaleWidth-1:0] req_scale,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [scdt_pkg::CharWidth-1:0]  rsp_text_char,
   output logic                                   rsp_last
);
   import scdt_pkg::*;

   state_type             state_ff,    state_in;
   text_mode_type         mode_ff,     mode_in;
   logic                  sign_ff,     sign_in;
   logic                  pt_done_ff,  pt_done_in;
   logic [RemWidth-1:0]   frac_ff,     frac_in;
   logic [RemWidth-1:0]   rem_ff,      rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  rsp_char_ff,  rsp_char_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic                  accept;
   logic                  load;
   logic                  dbl_start;
   logic [ValueWidth-1:0] mag;
   logic [ScaleWidth-1:0] neg_scale;
   logic [RemWidth-1:0]   num_digits;
   logic [RemWidth-1:0]   digit_idx;
   logic [3:0]            digit;
   bcd_type               dbl_bcd;
   dbl_status_type        dbl_status;

   // The magnitude is taken as an unsigned number, so the most negative
   // value converts without overflow.
   assign mag       = req_value[ValueWidth-1] ? (~$unsigned(req_value) + ValueWidth'(1))
                                              : $unsigned(req_value);
   assign neg_scale = ~$unsigned(req_scale) + ScaleWidth'(1);
   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // The output register may take a new character when it is empty or when
   // its present character leaves in this cycle.
   assign load = ~rsp_valid_ff | rsp_ready;

   assign num_digits = digit_count(dbl_bcd);
   assign digit_idx  = rem_ff - RemWidth'(1);
   assign digit      = dbl_bcd[{digit_idx, 2'b00} +: 4];

   scdt_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (dbl_start),
      .mag    (mag),
      .bcd    (dbl_bcd),
      .status (dbl_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= TXT_NUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sign_ff     <= sign_in;
      pt_done_ff  <= pt_done_in;
      frac_ff     <= frac_in;
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      sign_in      = sign_ff;
      pt_done_in   = pt_done_ff;
      frac_in      = frac_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      dbl_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sign_in    = req_value[ValueWidth-1];
               pt_done_in = 1'b0;
               // A negative scale gives the number of digits after the point.
               frac_in    = req_scale[ScaleWidth-1] ? neg_scale[RemWidth-1:0] : '0;
               if (req_value == '0) begin
                  mode_in  = TXT_ZERO;
                  rem_in   = RemWidth'(1);
                  state_in = ST_EMIT;
               end else if (int'(req_scale) < MIN_SCALE) begin
                  mode_in  = TXT_STAR;
                  rem_in   = RemWidth'(3);
                  state_in = ST_EMIT;
               end else begin
                  mode_in   = TXT_NUM;
                  dbl_start = 1'b1;
                  state_in  = ST_CONV;
               end
            end
         end

         ST_CONV: begin
            if (dbl_status.done) begin
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            // The text covers the significant digits, or the whole fraction
            // with zero padding when the value is shorter than the fraction.
            rem_in   = (num_digits > frac_ff) ? num_digits : frac_ff;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               case (mode_ff)
                  TXT_ZERO: begin
                     rsp_char_in = ChZero;
                     rsp_last_in = (rem_ff == RemWidth'(1));
                     rem_in      = rem_ff - RemWidth'(1);
                  end
                  TXT_STAR: begin
                     rsp_char_in = ChStar;
                     rsp_last_in = (rem_ff == RemWidth'(1));
                     rem_in      = rem_ff - RemWidth'(1);
                  end
                  default: begin
                     if (sign_ff) begin
                        rsp_char_in = ChMinus;
                        sign_in     = 1'b0;
                     end else if (frac_ff != '0 && !pt_done_ff && rem_ff == frac_ff) begin
                        // The point goes in just before the fraction digits.
                        rsp_char_in = ChPoint;
                        pt_done_in  = 1'b1;
                     end else begin
                        // Positions above the significant digits read as
                        // zero, which gives the padding after the point.
                        rsp_char_in = ChZero | CharWidth'(digit);
                        rsp_last_in = (rem_ff == RemWidth'(1));
                        rem_in      = rem_ff - RemWidth'(1);
                     end
                  end
               endcase
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // The conversion unit is only ever busy while a request is being worked on.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dbl_status.busy)
      else $error("conversion busy while taking requests");

   // The conversion result is only reported while the sequencer waits for it.
   a_done_conv: assert property (@(posedge clock) disable iff (reset)
      dbl_status.done |-> (state_ff == ST_CONV))
      else $error("conversion finished outside the conversion state");

   // While characters are being sent, at least one position is left.
   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != '0))
      else $error("character sequencer ran out of positions");

   // An accepted request always starts work.
   a_accept_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request was dropped");

endmodule
